/* hdl/grc_pkg.sv */
package grc_pkg;

	localparam int SCREEN_WIDTH = 640;
	localparam int GRID_SIZE    = 32;
	localparam int FRAC_BITS    = 16;

	localparam int CELL_W    = $clog2(GRID_SIZE);
	localparam int ADDR_W    = 2 * CELL_W;
	localparam int MAP_DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int COL_W     = 10;
	localparam int POS_W     = 21;
	localparam int VEC_W     = 18;
	localparam int DIST_W    = 24;
	localparam int CAM_W     = 20;
	localparam int PROD_W    = VEC_W + CAM_W;
	localparam int RAY_W     = 21;
	localparam int ABS_W     = 20;
	localparam int DIV_W     = 40;
	localparam int DELTA_W   = 2 * FRAC_BITS + 1;
	localparam int FR_W      = FRAC_BITS + 1;
	localparam int SD_W      = 40;
	localparam int N_W       = 24;
	localparam int MC_W      = CELL_W + 2;

	// camera x by reciprocal multiplication, exact over the whole column range
	localparam int     CAM_SH  = 40;
	localparam int     CAM_SHR = CAM_SH - FRAC_BITS - 1;
	localparam int     RCP_W   = 32;
	localparam int     CAMP_W  = COL_W + RCP_W;
	localparam longint CAM_RCP = ((64'sd1 <<< CAM_SH) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CAST  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;

	localparam logic        [POS_W-1:0] RST_POS_X   = 21'd98304;
	localparam logic        [POS_W-1:0] RST_POS_Y   = 21'd98304;
	localparam logic signed [VEC_W-1:0] RST_DIR_X   = -18'sd65536;
	localparam logic signed [VEC_W-1:0] RST_DIR_Y   = 18'sd0;
	localparam logic signed [VEC_W-1:0] RST_PLANE_X = 18'sd0;
	localparam logic signed [VEC_W-1:0] RST_PLANE_Y = 18'sd43253;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic              func;
		logic [COL_W-1:0]  column;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic              cell_wall;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]  ray_column;
		logic              wall_found;
		logic [CELL_W-1:0] hit_x;
		logic [CELL_W-1:0] hit_y;
		logic              hit_side;
		logic [DIST_W-1:0] perp_dist;
	} res_t;

	typedef struct packed {
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
	} cfg_t;

	typedef struct packed {
		logic              cast;
		logic [COL_W-1:0]  column;
		logic [ADDR_W-1:0] addr;
		logic              wall;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

endpackage

/* hdl/grc_ram.sv */
module grc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/grc_div.sv */
module grc_div import grc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIV_W-1:0] dividend,
	input  logic [ABS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dq_q;
	logic [ABS_W-1:0] rem_q;
	logic [ABS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [ABS_W:0]   trial;
	logic [ABS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[ABS_W-1:0] : trial[ABS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

/* hdl/grc_front.sv */
module grc_front import grc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cmd_t      cmd,
	output logic      busy,
	input  back_ctl_t bctl,
	output head_t     head
);

	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	entry_t           q_mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;
	entry_t           ent;

	assign busy = (count_q == CNT_W'(Q_DEPTH)) || bctl.clearing;
	assign push = start && !busy;
	assign pop  = bctl.pop && (count_q != '0);

	// classify the incoming transaction
	always_comb begin
		ent.cast   = (cmd.func == FUNC_CAST);
		ent.column = cmd.column;
		ent.addr   = {cmd.cell_x, cmd.cell_y};
		ent.wall   = cmd.cell_wall;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = q_mem_q[rd_ptr_q];

endmodule

/* hdl/grc_back.sv */
module grc_back import grc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  head_t     head,
	output back_ctl_t bctl,
	output logic      done,
	output res_t      res
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CAM_L, S_CAM_W, S_RAY1, S_RAY2,
		S_DX_L, S_DX_W, S_DY_L, S_DY_W,
		S_SDX1, S_SDX2, S_SDY1, S_SDY2,
		S_STEP, S_CHK, S_RD, S_PN, S_PD, S_PD_W
	} state_t;

	state_t                   state_q;
	logic [ADDR_W-1:0]        clr_q;
	logic [COL_W-1:0]         column_q;
	logic [CAMP_W-1:0]        camp_q;
	logic signed [CAM_W-1:0]  cam_q;
	logic signed [PROD_W-1:0] prodx_q;
	logic signed [PROD_W-1:0] prody_q;
	logic signed [RAY_W-1:0]  rx_q;
	logic signed [RAY_W-1:0]  ry_q;
	logic [DELTA_W-1:0]       dx_q;
	logic [DELTA_W-1:0]       dy_q;
	logic [2*FR_W-1:0]        phi_q;
	logic [2*FR_W-2:0]        plo_q;
	logic [SD_W-1:0]          sdx_q;
	logic [SD_W-1:0]          sdy_q;
	logic [MC_W-1:0]          mx_q;
	logic [MC_W-1:0]          my_q;
	logic                     side_q;
	logic signed [N_W-1:0]    n_q;
	logic signed [RAY_W-1:0]  nray_q;
	logic                     div_go_q;
	logic [DIV_W-1:0]         div_a_q;
	logic [ABS_W-1:0]         div_b_q;
	logic                     done_q;
	res_t                     res_q;

	logic                     div_done;
	logic [DIV_W-1:0]         div_quot;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic                     ram_wdata;
	logic                     ram_rdata;

	logic [ABS_W-1:0]         abs_rx;
	logic [ABS_W-1:0]         abs_ry;
	logic [ABS_W-1:0]         abs_nray;
	logic [N_W-1:0]           abs_n;
	logic [FR_W-1:0]          frac_x;
	logic [FR_W-1:0]          frac_y;
	logic [FR_W-1:0]          m_frac;
	logic [DELTA_W-1:0]       m_d;
	logic                     infx;
	logic                     infy;
	logic                     step_x;
	logic                     out_x;
	logic                     out_y;
	logic signed [N_W-1:0]    mpos;
	logic signed [N_W-1:0]    ppos;
	logic signed [N_W-1:0]    nval;

	assign abs_rx   = ABS_W'(rx_q[RAY_W-1] ? -rx_q : rx_q);
	assign abs_ry   = ABS_W'(ry_q[RAY_W-1] ? -ry_q : ry_q);
	assign abs_nray = ABS_W'(nray_q[RAY_W-1] ? -nray_q : nray_q);
	assign abs_n    = n_q[N_W-1] ? N_W'(-n_q) : N_W'(n_q);

	assign frac_x = rx_q[RAY_W-1] ? {1'b0, cfg.pos_x[FRAC_BITS-1:0]}
		: FR_W'(1 << FRAC_BITS) - {1'b0, cfg.pos_x[FRAC_BITS-1:0]};
	assign frac_y = ry_q[RAY_W-1] ? {1'b0, cfg.pos_y[FRAC_BITS-1:0]}
		: FR_W'(1 << FRAC_BITS) - {1'b0, cfg.pos_y[FRAC_BITS-1:0]};
	assign m_frac = (state_q == S_SDY1) ? frac_y : frac_x;
	assign m_d    = (state_q == S_SDY1) ? dy_q : dx_q;

	assign infx   = (rx_q == '0);
	assign infy   = (ry_q == '0);
	assign step_x = !infx && (infy || (sdx_q < sdy_q));
	assign out_x  = mx_q[MC_W-1] || (mx_q[MC_W-2:0] >= (MC_W-1)'(GRID_SIZE));
	assign out_y  = my_q[MC_W-1] || (my_q[MC_W-2:0] >= (MC_W-1)'(GRID_SIZE));

	always_comb begin
		mpos = side_q ? N_W'({my_q[CELL_W-1:0], {FRAC_BITS{1'b0}}})
			: N_W'({mx_q[CELL_W-1:0], {FRAC_BITS{1'b0}}});
		ppos = side_q ? N_W'(cfg.pos_y) : N_W'(cfg.pos_x);
		nval = mpos - ppos;
		if ((side_q && ry_q[RAY_W-1]) || (!side_q && rx_q[RAY_W-1])) begin
			nval = nval + N_W'(1 << FRAC_BITS);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head.entry.addr;
		ram_wdata = head.entry.wall;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 1'b0;
			end
			S_IDLE: begin
				ram_we = head.valid && !head.entry.cast;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	grc_ram #(
		.WIDTH(1),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr({mx_q[CELL_W-1:0], my_q[CELL_W-1:0]}),
		.rdata(ram_rdata)
	);

	grc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go_q),
		.dividend(div_a_q),
		.divisor (div_b_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MAP_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head.valid && head.entry.cast) begin
						column_q <= head.entry.column;
						state_q  <= S_CAM_L;
					end
				end
				S_CAM_L: begin
					camp_q  <= column_q * RCP_W'(CAM_RCP);
					state_q <= S_CAM_W;
				end
				S_CAM_W: begin
					cam_q   <= $signed(CAM_W'(camp_q >> CAM_SHR) - CAM_W'(1 << FRAC_BITS));
					state_q <= S_RAY1;
				end
				S_RAY1: begin
					prodx_q <= cfg.plane_x * cam_q;
					prody_q <= cfg.plane_y * cam_q;
					state_q <= S_RAY2;
				end
				S_RAY2: begin
					rx_q    <= RAY_W'(cfg.dir_x + (prodx_q >>> FRAC_BITS));
					ry_q    <= RAY_W'(cfg.dir_y + (prody_q >>> FRAC_BITS));
					state_q <= S_DX_L;
				end
				S_DX_L: begin
					if (infx) begin
						dx_q    <= '0;
						state_q <= S_DY_L;
					end else begin
						div_a_q  <= DIV_W'(1) << (2 * FRAC_BITS);
						div_b_q  <= abs_rx;
						div_go_q <= 1'b1;
						state_q  <= S_DX_W;
					end
				end
				S_DX_W: begin
					if (div_done) begin
						dx_q    <= div_quot[DELTA_W-1:0];
						state_q <= S_DY_L;
					end
				end
				S_DY_L: begin
					if (infy) begin
						dy_q    <= '0;
						state_q <= S_SDX1;
					end else begin
						div_a_q  <= DIV_W'(1) << (2 * FRAC_BITS);
						div_b_q  <= abs_ry;
						div_go_q <= 1'b1;
						state_q  <= S_DY_W;
					end
				end
				S_DY_W: begin
					if (div_done) begin
						dy_q    <= div_quot[DELTA_W-1:0];
						state_q <= S_SDX1;
					end
				end
				S_SDX1: begin
					phi_q   <= m_frac * m_d[DELTA_W-1:FRAC_BITS];
					plo_q   <= m_frac * m_d[FRAC_BITS-1:0];
					state_q <= S_SDX2;
				end
				S_SDX2: begin
					sdx_q   <= SD_W'(phi_q) + SD_W'(plo_q >> FRAC_BITS);
					state_q <= S_SDY1;
				end
				S_SDY1: begin
					phi_q   <= m_frac * m_d[DELTA_W-1:FRAC_BITS];
					plo_q   <= m_frac * m_d[FRAC_BITS-1:0];
					state_q <= S_SDY2;
				end
				S_SDY2: begin
					sdy_q   <= SD_W'(phi_q) + SD_W'(plo_q >> FRAC_BITS);
					mx_q    <= MC_W'(cfg.pos_x[POS_W-1:FRAC_BITS]);
					my_q    <= MC_W'(cfg.pos_y[POS_W-1:FRAC_BITS]);
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (step_x) begin
						sdx_q  <= sdx_q + SD_W'(dx_q);
						mx_q   <= rx_q[RAY_W-1] ? mx_q - MC_W'(1) : mx_q + MC_W'(1);
						side_q <= 1'b0;
					end else begin
						sdy_q  <= sdy_q + SD_W'(dy_q);
						my_q   <= ry_q[RAY_W-1] ? my_q - MC_W'(1) : my_q + MC_W'(1);
						side_q <= 1'b1;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (out_x || out_y) begin
						res_q.ray_column <= column_q;
						res_q.wall_found <= 1'b0;
						res_q.hit_x      <= '0;
						res_q.hit_y      <= '0;
						res_q.hit_side   <= side_q;
						res_q.perp_dist  <= '0;
						done_q           <= 1'b1;
						state_q          <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= ram_rdata ? S_PN : S_STEP;
				end
				S_PN: begin
					n_q     <= nval;
					nray_q  <= side_q ? ry_q : rx_q;
					state_q <= S_PD;
				end
				S_PD: begin
					res_q.ray_column <= column_q;
					res_q.wall_found <= 1'b1;
					res_q.hit_x      <= mx_q[CELL_W-1:0];
					res_q.hit_y      <= my_q[CELL_W-1:0];
					res_q.hit_side   <= side_q;
					if (nray_q == '0) begin
						res_q.perp_dist <= DIST_MAX;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else if ((n_q != '0) && (n_q[N_W-1] != nray_q[RAY_W-1])) begin
						res_q.perp_dist <= '0;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						div_a_q  <= DIV_W'(abs_n) << FRAC_BITS;
						div_b_q  <= abs_nray;
						div_go_q <= 1'b1;
						state_q  <= S_PD_W;
					end
				end
				S_PD_W: begin
					if (div_done) begin
						res_q.perp_dist <= (div_quot[DIV_W-1:DIST_W] != '0) ? DIST_MAX
							: div_quot[DIST_W-1:0];
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign bctl.pop      = (state_q == S_IDLE);
	assign bctl.clearing = (state_q == S_CLEAR);
	assign done          = done_q;
	assign res           = res_q;

endmodule

/* hdl/grid_ray_caster.sv */
// a map write lands in the map the cycle after it is accepted when the back end is idle and
// nothing is queued ahead of it, and gives no result; a cast result's time is set by up to
// three 40-step serial divisions and the map read of each dda step (S_STEP, S_CHK, S_RD)
// throughput: one item at a time in the back end, two more wait in the front queue
// reset: config registers take their reset values, then a map clearing pass over all 1024 cells holds busy
// results are strobed by done for one cycle; the receiver cannot stall
module grid_ray_caster import grc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cmd_t                  cmd,
	output logic                  busy,
	output logic                  done,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	head_t     head;
	back_ctl_t bctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x   <= RST_POS_X;
			cfg_q.pos_y   <= RST_POS_Y;
			cfg_q.dir_x   <= RST_DIR_X;
			cfg_q.dir_y   <= RST_DIR_Y;
			cfg_q.plane_x <= RST_PLANE_X;
			cfg_q.plane_y <= RST_PLANE_Y;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POS_X:   cfg_q.pos_x   <= cfg_data[POS_W-1:0];
				REG_POS_Y:   cfg_q.pos_y   <= cfg_data[POS_W-1:0];
				REG_DIR_X:   cfg_q.dir_x   <= cfg_data[VEC_W-1:0];
				REG_DIR_Y:   cfg_q.dir_y   <= cfg_data[VEC_W-1:0];
				REG_PLANE_X: cfg_q.plane_x <= cfg_data[VEC_W-1:0];
				REG_PLANE_Y: cfg_q.plane_y <= cfg_data[VEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	grc_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.bctl  (bctl),
		.head  (head)
	);

	grc_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.head  (head),
		.bctl  (bctl),
		.done  (done),
		.res   (res)
	);

endmodule

/* hdl/grc_checker.sv */
module grc_checker import grc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_t cmd,
	input logic busy,
	input logic done,
	input res_t res
);

	logic [2:0] pend_q;
	logic       cast_acc;

	assign cast_acc = start && !busy && (cmd.func == FUNC_CAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cast_acc && !done) begin
			pend_q <= pend_q + 3'd1;
		end else if (done && !cast_acc) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	// every result belongs to an accepted cast transaction
	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pend_q != '0))
		else $error("result without an outstanding cast");

	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.wall_found) |->
			(res.hit_x == '0) && (res.hit_y == '0) && (res.perp_dist == '0))
		else $error("miss result carries nonzero hit data");

endmodule

bind grid_ray_caster grc_checker u_grc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.cmd   (cmd),
	.busy  (busy),
	.done  (done),
	.res   (res)
);

/* tb/grid_ray_caster_tb.sv */
module grid_ray_caster_tb;
	import grc_pkg::*;

	localparam int MAX_MISMATCH_PRINT = 10;
	localparam int WATCHDOG_LIMIT     = 20000;
	localparam longint DIST_SAT       = 64'd16777215;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	class cast_scoreboard;
		bit         wall_map [MAP_DEPTH];
		cfg_t       regs;
		res_t       pending [$];
		int         mismatches;

		function void reset_state();
			foreach (wall_map[i]) wall_map[i] = 1'b0;
			regs.pos_x   = RST_POS_X;
			regs.pos_y   = RST_POS_Y;
			regs.dir_x   = RST_DIR_X;
			regs.dir_y   = RST_DIR_Y;
			regs.plane_x = RST_PLANE_X;
			regs.plane_y = RST_PLANE_Y;
			pending.delete();
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_POS_X:   regs.pos_x   = data[POS_W-1:0];
				REG_POS_Y:   regs.pos_y   = data[POS_W-1:0];
				REG_DIR_X:   regs.dir_x   = data[VEC_W-1:0];
				REG_DIR_Y:   regs.dir_y   = data[VEC_W-1:0];
				REG_PLANE_X: regs.plane_x = data[VEC_W-1:0];
				REG_PLANE_Y: regs.plane_y = data[VEC_W-1:0];
				default: ;
			endcase
		endfunction

		function longint floor_div_frac(longint v);
			if (v >= 0) return v >>> FRAC_BITS;
			return -((-v + (64'sd1 << FRAC_BITS) - 1) >>> FRAC_BITS);
		endfunction

		function longint wall_distance(longint n, longint ray);
			longint q, ar, an;
			if (ray == 0) return DIST_SAT;
			if (((n < 0) != (ray < 0)) && n != 0) return 0;
			ar = ray < 0 ? -ray : ray;
			an = n < 0 ? -n : n;
			q  = (an << FRAC_BITS) / ar;
			return q > DIST_SAT ? DIST_SAT : q;
		endfunction

		function void note_command(cmd_t c);
			longint one, cam, rx, ry, mx, my, px, py, stx, sty;
			longint dx, dy, sdx, sdy, n, d;
			bit infx, infy, found, side;
			res_t r;
			one = 64'sd1 << FRAC_BITS;
			if (c.func == FUNC_WRITE) begin
				wall_map[{c.cell_x, c.cell_y}] = c.cell_wall;
				return;
			end
			px  = regs.pos_x;
			py  = regs.pos_y;
			cam = ((2 * longint'(c.column)) << FRAC_BITS) / SCREEN_WIDTH - one;
			rx  = longint'(regs.dir_x) + floor_div_frac(longint'(regs.plane_x) * cam);
			ry  = longint'(regs.dir_y) + floor_div_frac(longint'(regs.plane_y) * cam);
			mx  = px >>> FRAC_BITS;
			my  = py >>> FRAC_BITS;
			infx = (rx == 0);
			infy = (ry == 0);
			dx = infx ? 0 : (64'sd1 << (2 * FRAC_BITS)) / (rx < 0 ? -rx : rx);
			dy = infy ? 0 : (64'sd1 << (2 * FRAC_BITS)) / (ry < 0 ? -ry : ry);
			if (rx < 0) begin
				stx = -1; sdx = ((px - (mx << FRAC_BITS)) * dx) >>> FRAC_BITS;
			end else begin
				stx = 1;  sdx = (((mx << FRAC_BITS) + one - px) * dx) >>> FRAC_BITS;
			end
			if (ry < 0) begin
				sty = -1; sdy = ((py - (my << FRAC_BITS)) * dy) >>> FRAC_BITS;
			end else begin
				sty = 1;  sdy = (((my << FRAC_BITS) + one - py) * dy) >>> FRAC_BITS;
			end
			found = 0;
			side  = 0;
			forever begin
				if (!infx && (infy || sdx < sdy)) begin
					sdx += dx; mx += stx; side = 0;
				end else begin
					sdy += dy; my += sty; side = 1;
				end
				if (mx < 0 || mx >= GRID_SIZE || my < 0 || my >= GRID_SIZE) break;
				if (wall_map[mx * GRID_SIZE + my]) begin
					found = 1;
					break;
				end
			end
			r = '0;
			r.ray_column = c.column;
			r.wall_found = found;
			r.hit_side   = side;
			if (found) begin
				if (!side) begin
					n = (mx << FRAC_BITS) - px + (stx < 0 ? one : 0);
					d = wall_distance(n, rx);
				end else begin
					n = (my << FRAC_BITS) - py + (sty < 0 ? one : 0);
					d = wall_distance(n, ry);
				end
				r.hit_x     = mx[CELL_W-1:0];
				r.hit_y     = my[CELL_W-1:0];
				r.perp_dist = d[DIST_W-1:0];
			end
			pending.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_MISMATCH_PRINT)
					$display("unexpected result: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_MISMATCH_PRINT)
					$display("mismatch col %0d: expected %p, actual %p",
						want.ray_column, want, got);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	cmd_t                  cmd;
	logic                  busy;
	logic                  done;
	res_t                  res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cast_scoreboard sb;
	int  idle_cycles;
	bit  no_gaps;
	bit  timed_out;

	grid_ray_caster uut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.done(done), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(res);
			if ((start && !busy) || (cfg_valid && cfg_ready) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
				timed_out = 1;
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// start drops only while idling
	task automatic random_gap();
		if (!no_gaps)
			while ($urandom_range(99) < 22) begin
				start <= 1'b0;
				@(negedge clk);
			end
	endtask

	task automatic send_command(cmd_t c);
		random_gap();
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sb.note_command(c);
		@(negedge clk);
	endtask

	task automatic write_cell(int x, int y, bit w);
		cmd_t c;
		c = '0;
		c.func = FUNC_WRITE; c.cell_x = CELL_W'(x); c.cell_y = CELL_W'(y); c.cell_wall = w;
		send_command(c);
	endtask

	task automatic cast_column(int col);
		cmd_t c;
		c = $bits(cmd_t)'($urandom);
		c.func = FUNC_CAST; c.column = COL_W'(col);
		send_command(c);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic set_view(int px, int py, int dx, int dy, int plx, int ply);
		write_reg(REG_POS_X, CFG_DATA_W'(px));
		write_reg(REG_POS_Y, CFG_DATA_W'(py));
		write_reg(REG_DIR_X, CFG_DATA_W'(dx));
		write_reg(REG_DIR_Y, CFG_DATA_W'(dy));
		write_reg(REG_PLANE_X, CFG_DATA_W'(plx));
		write_reg(REG_PLANE_Y, CFG_DATA_W'(ply));
		cfg_valid <= 1'b0;
	endtask

	task automatic build_room();
		for (int i = 0; i < GRID_SIZE; i++) begin
			write_cell(i, 0, 1);
			write_cell(i, GRID_SIZE - 1, 1);
			write_cell(0, i, 1);
			write_cell(GRID_SIZE - 1, i, 1);
		end
	endtask

	task automatic random_phase(int n_items, int wall_pct);
		cmd_t c;
		for (int i = 0; i < n_items; i++) begin
			c = $bits(cmd_t)'($urandom);
			if ($urandom_range(99) < 60) begin
				c.func = FUNC_CAST;
				c.column = ($urandom_range(19) == 0) ? COL_W'($urandom_range(1023, 640))
					: COL_W'($urandom_range(639));
			end else begin
				c.func = FUNC_WRITE;
				c.cell_wall = $urandom_range(99) < wall_pct;
			end
			send_command(c);
		end
	endtask

	function automatic int rand_vec();
		case ($urandom_range(5))
			0: return -131072;
			1: return 131071;
			2: return 0;
			default: return $urandom_range(262143) - 131072;
		endcase
	endfunction

	initial begin
		sb = new();
		sb.reset_state();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_cycles = 0;
		no_gaps = 0;
		timed_out = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty map, then a closed room, edge columns and extremes
		cast_column(0);
		cast_column(SCREEN_WIDTH / 2);
		build_room();
		cast_column(0);
		cast_column(SCREEN_WIDTH - 1);
		cast_column(1023);
		write_cell(3, 1, 1);
		write_cell(3, 1, 0);
		drain();
		// axis-aligned rays: zero components, both zero
		set_view(5 << 16, 5 << 16, 65536, 0, 0, 0);
		cast_column(320);
		cast_column(0);
		drain();
		set_view(5 << 16, 5 << 16, 0, 0, 0, 0);
		cast_column(100);
		drain();
		// start at the map corners, extreme registers
		set_view(2097151, 2097151, -131072, -131072, 131071, -131072);
		cast_column(0);
		cast_column(639);
		drain();
		set_view(0, 0, 131071, 131071, -131072, 131071);
		cast_column(0);
		cast_column(639);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			no_gaps = (ph == 2);
			if (ph < 4)
				set_view($urandom_range(30 << 16, 1 << 16), $urandom_range(30 << 16, 1 << 16),
					rand_vec(), rand_vec(), rand_vec(), rand_vec());
			else
				set_view($urandom_range(2097151), $urandom_range(2097151),
					rand_vec(), rand_vec(), rand_vec(), rand_vec());
			if (ph == 0) build_room();
			random_phase(160, ph < 3 ? 30 : 60);
			drain();
		end
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		random_phase(20, 50);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
